// ===== design/ptrs_pkg.sv =====
`default_nettype none
package ptrs_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int TIME_BITS     = 32;
  localparam int IDENT_BITS    = 8;
  localparam int OFFSET_BITS   = 31;

  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_LOAD   = 3'd1;
  localparam logic [2:0] KIND_HIT    = 3'd2;
  localparam logic [2:0] KIND_NEXT   = 3'd3;
  localparam logic [2:0] KIND_RETIRE = 3'd4;

  localparam logic [1:0] CLS_CONT = 2'd0;
  localparam logic [1:0] CLS_PER  = 2'd1;
  localparam logic [1:0] CLS_ONE  = 2'd2;
  localparam logic [1:0] CLS_NONE = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONT,
    ST_ONE,
    ST_PER,
    ST_DIV,
    ST_NEXT,
    ST_RETIRE,
    ST_HIT,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic load_item;
    logic idx_clr;
    logic idx_inc;
    logic hit_take;
    logic div_start;
    logic cand_imm;
    logic cand_div;
    logic keep_copy;
    logic final_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       at_end;
    logic       t_neg;
    logic       cont_hit;
    logic       one_hit;
    logic       per_elig;
    logic       p_zero;
    logic       d_zero;
    logic       next_imm;
    logic       next_div;
    logic       keep;
    logic       div_busy;
    logic       rem_zero;
    logic       pend_valid;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/periodic_task_release_scheduler_unit.sv =====
// Clear, load and ignored kinds go straight to the final result. Retire and next-time query
// walk the live entries (a next-time query at negative time skips the walk); a hit query
// walks them in passes for continuous, one-shot and periodic entries with a step for each
// hit, and every periodic entry that needs a remainder runs the bit-serial divider.
// One transaction at a time: in_stall stays high until the final result is registered, and
// the next is accepted in the cycle after that.
// Reset: synchronous, active high; empties the task table and drops any result.
`default_nettype none
module periodic_task_release_scheduler_unit #(
  parameter int MAX_TASKS = ptrs_pkg::MAX_TASKS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [2:0]                            kind,
  input  wire  signed [ptrs_pkg::TIME_BITS-1:0] query_time,
  input  wire  [ptrs_pkg::IDENT_BITS-1:0]       task_ident,
  input  wire  [1:0]                            task_class,
  input  wire  [ptrs_pkg::OFFSET_BITS-1:0]      task_offset,
  input  wire  [ptrs_pkg::OFFSET_BITS-1:0]      task_period,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [ptrs_pkg::IDENT_BITS-1:0]       hit_ident,
  output logic                                  hit_valid,
  output logic [ptrs_pkg::TIME_BITS-1:0]        next_event_time,
  output logic                                  no_event,
  output logic                                  status_code,
  output logic                                  last_result
);
  import ptrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ptrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptrs_dpath #(.MAX_TASKS(MAX_TASKS)) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .kind            (kind),
    .query_time      (query_time),
    .task_ident      (task_ident),
    .task_class      (task_class),
    .task_offset     (task_offset),
    .task_period     (task_period),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .hit_ident       (hit_ident),
    .hit_valid       (hit_valid),
    .next_event_time (next_event_time),
    .no_event        (no_event),
    .status_code     (status_code),
    .last_result     (last_result),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
`default_nettype wire

// ===== design/ptrs_ctrl.sv =====
`default_nettype none
module ptrs_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  input  wire  [2:0]       kind,
  output logic             in_stall,
  input  ptrs_pkg::sts_t   sts,
  output ptrs_pkg::cmd_t   cmd
);
  import ptrs_pkg::*;

  state_t state, state_next;
  state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            KIND_HIT:    state_next = ST_CONT;
            KIND_NEXT:   state_next = ST_NEXT;
            KIND_RETIRE: state_next = ST_RETIRE;
            default:     state_next = ST_FINAL;
          endcase
        end
      end
      ST_CONT: begin
        if (sts.at_end) state_next = ST_ONE;
        else if (sts.cont_hit) begin
          state_next = ST_HIT;
          ret_next   = ST_CONT;
        end
      end
      ST_ONE: begin
        if (sts.at_end) state_next = ST_PER;
        else if (sts.one_hit) begin
          state_next = ST_HIT;
          ret_next   = ST_ONE;
        end
      end
      ST_PER: begin
        if (sts.at_end) state_next = ST_FINAL;
        else if (sts.per_elig) begin
          if (!sts.p_zero) state_next = ST_DIV;
          else if (sts.d_zero) begin
            state_next = ST_HIT;
            ret_next   = ST_PER;
          end
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          if (sts.kind == KIND_HIT) begin
            if (sts.rem_zero) begin
              state_next = ST_HIT;
              ret_next   = ST_PER;
            end else begin
              state_next = ST_PER;
            end
          end else begin
            state_next = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        if (sts.t_neg || sts.at_end) state_next = ST_FINAL;
        else if (sts.next_div) state_next = ST_DIV;
      end
      ST_RETIRE: begin
        if (sts.at_end) state_next = ST_FINAL;
      end
      ST_HIT: begin
        if (!sts.pend_valid || sts.out_free) state_next = ret;
      end
      ST_FINAL: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.load_item = in_valid;
        cmd.idx_clr   = in_valid;
      end
      ST_CONT: begin
        if (sts.at_end) cmd.idx_clr = 1'b1;
        else if (!sts.cont_hit) cmd.idx_inc = 1'b1;
      end
      ST_ONE: begin
        if (sts.at_end) cmd.idx_clr = 1'b1;
        else if (!sts.one_hit) cmd.idx_inc = 1'b1;
      end
      ST_PER: begin
        if (!sts.at_end) begin
          if (sts.per_elig && !sts.p_zero) cmd.div_start = 1'b1;
          else if (!(sts.per_elig && sts.d_zero)) cmd.idx_inc = 1'b1;
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          if (sts.kind == KIND_HIT) begin
            cmd.idx_inc = !sts.rem_zero;
          end else begin
            cmd.cand_div = 1'b1;
            cmd.idx_inc  = 1'b1;
          end
        end
      end
      ST_NEXT: begin
        if (!(sts.t_neg || sts.at_end)) begin
          if (sts.next_div) cmd.div_start = 1'b1;
          else begin
            cmd.cand_imm = sts.next_imm;
            cmd.idx_inc  = 1'b1;
          end
        end
      end
      ST_RETIRE: begin
        if (!sts.at_end) begin
          cmd.keep_copy = sts.keep;
          cmd.idx_inc   = 1'b1;
        end
      end
      ST_HIT: begin
        if (!sts.pend_valid || sts.out_free) begin
          cmd.hit_take = 1'b1;
          cmd.idx_inc  = 1'b1;
        end
      end
      ST_FINAL: begin
        cmd.final_out = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/ptrs_dpath.sv =====
`default_nettype none
module ptrs_dpath #(
  parameter int MAX_TASKS = ptrs_pkg::MAX_TASKS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire  [2:0]                           kind,
  input  wire  signed [ptrs_pkg::TIME_BITS-1:0] query_time,
  input  wire  [ptrs_pkg::IDENT_BITS-1:0]      task_ident,
  input  wire  [1:0]                           task_class,
  input  wire  [ptrs_pkg::OFFSET_BITS-1:0]     task_offset,
  input  wire  [ptrs_pkg::OFFSET_BITS-1:0]     task_period,
  input  wire                                  out_stall,
  output logic                                 out_valid,
  output logic [ptrs_pkg::IDENT_BITS-1:0]      hit_ident,
  output logic                                 hit_valid,
  output logic [ptrs_pkg::TIME_BITS-1:0]       next_event_time,
  output logic                                 no_event,
  output logic                                 status_code,
  output logic                                 last_result,
  input  ptrs_pkg::cmd_t                       cmd,
  output ptrs_pkg::sts_t                       sts
);
  import ptrs_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int DW = $clog2(TIME_BITS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TASKS);

  logic [1:0]             entry_class  [MAX_TASKS];
  logic [IDENT_BITS-1:0]  entry_ident  [MAX_TASKS];
  logic [OFFSET_BITS-1:0] entry_offset [MAX_TASKS];
  logic [OFFSET_BITS-1:0] entry_period [MAX_TASKS];

  logic [CW-1:0] entry_count, idx, wptr;
  logic [2:0]             k;
  logic [TIME_BITS-1:0]   t;
  logic [IDENT_BITS-1:0]  l_ident;
  logic [1:0]             l_class;
  logic [OFFSET_BITS-1:0] l_offset, l_period;
  logic [IDENT_BITS-1:0]  pend_ident;
  logic                   pend_valid;
  logic                   found;
  logic [TIME_BITS-1:0]   best;
  logic [TIME_BITS-1:0]   dq, rem;
  logic [DW-1:0]          dcnt;

  logic [IW-1:0]          ri;
  logic [1:0]             c_class;
  logic [OFFSET_BITS-1:0] c_off, c_per;
  logic [TIME_BITS-1:0]   off_x, per_x, span, rsh, cand, cand_d;
  logic                   t_ge_off, t_eq_off, out_free, full;

  assign ri      = idx[IW-1:0];
  assign c_class = entry_class[ri];
  assign c_off   = entry_offset[ri];
  assign c_per   = entry_period[ri];
  assign off_x   = TIME_BITS'(c_off);
  assign per_x   = TIME_BITS'(c_per);
  assign t_ge_off = $signed(t) >= $signed(off_x);
  assign t_eq_off = (t == off_x);
  assign span     = t - off_x;
  assign rsh      = {rem[TIME_BITS-2:0], dq[TIME_BITS-1]};
  assign cand_d   = (rem == '0) ? t : (t + per_x - rem);
  assign cand     = cmd.cand_div ? cand_d : off_x;
  assign out_free = !out_valid || !out_stall;
  assign full     = (entry_count >= FULL_COUNT);

  always_comb begin
    sts            = '0;
    sts.kind       = k;
    sts.at_end     = (idx == entry_count);
    sts.t_neg      = t[TIME_BITS-1];
    sts.cont_hit   = (c_class == CLS_CONT);
    sts.one_hit    = (c_class == CLS_ONE) && t_eq_off;
    sts.per_elig   = (c_class == CLS_PER) && t_ge_off;
    sts.p_zero     = (c_per == '0);
    sts.d_zero     = (span == '0);
    sts.next_imm   = (c_class == CLS_ONE) || ((c_class == CLS_PER) && !t_ge_off)
                     || ((c_class == CLS_PER) && t_eq_off);
    sts.next_div   = (c_class == CLS_PER) && t_ge_off && !t_eq_off && (c_per != '0);
    sts.keep       = !((c_class == CLS_ONE) && t_ge_off);
    sts.div_busy   = (dcnt != '0);
    sts.rem_zero   = (rem == '0);
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      k        <= kind;
      t        <= query_time;
      l_ident  <= task_ident;
      l_class  <= task_class;
      l_offset <= task_offset;
      l_period <= task_period;
    end
    if (cmd.keep_copy) begin
      entry_class[wptr[IW-1:0]]  <= c_class;
      entry_ident[wptr[IW-1:0]]  <= entry_ident[ri];
      entry_offset[wptr[IW-1:0]] <= c_off;
      entry_period[wptr[IW-1:0]] <= c_per;
    end else if (cmd.final_out && k == KIND_LOAD && l_class != CLS_NONE && !full) begin
      entry_class[entry_count[IW-1:0]]  <= l_class;
      entry_ident[entry_count[IW-1:0]]  <= l_ident;
      entry_offset[entry_count[IW-1:0]] <= l_offset;
      entry_period[entry_count[IW-1:0]] <= l_period;
    end
    if (cmd.div_start) begin
      dq  <= span;
      rem <= '0;
    end else if (dcnt != '0) begin
      dq  <= {dq[TIME_BITS-2:0], 1'b0};
      rem <= (rsh >= per_x) ? (rsh - per_x) : rsh;
    end
    if (cmd.cand_imm || cmd.cand_div) begin
      if (!found || cand < best) best <= cand;
    end
    if (cmd.hit_take) pend_ident <= entry_ident[ri];
    if (cmd.hit_take && pend_valid) begin
      hit_ident       <= pend_ident;
      hit_valid       <= 1'b1;
      next_event_time <= '0;
      no_event        <= 1'b0;
      status_code     <= 1'b0;
      last_result     <= 1'b0;
    end else if (cmd.final_out) begin
      hit_ident       <= (k == KIND_HIT && pend_valid) ? pend_ident : '0;
      hit_valid       <= (k == KIND_HIT) && pend_valid;
      next_event_time <= (k == KIND_NEXT && !t[TIME_BITS-1] && found) ? best : '0;
      no_event        <= (k == KIND_NEXT) && !t[TIME_BITS-1] && !found;
      status_code     <= (k == KIND_LOAD) && (l_class != CLS_NONE) && full;
      last_result     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      idx         <= '0;
      wptr        <= '0;
      pend_valid  <= 1'b0;
      found       <= 1'b0;
      dcnt        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc) idx <= idx + 1'b1;
      if (cmd.load_item) wptr <= '0;
      else if (cmd.keep_copy) wptr <= wptr + 1'b1;
      if (cmd.load_item) pend_valid <= 1'b0;
      else if (cmd.hit_take) pend_valid <= 1'b1;
      if (cmd.load_item) found <= 1'b0;
      else if (cmd.cand_imm || cmd.cand_div) found <= 1'b1;
      if (cmd.div_start) dcnt <= DW'(TIME_BITS);
      else if (dcnt != '0) dcnt <= dcnt - 1'b1;
      if ((cmd.hit_take && pend_valid) || cmd.final_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cmd.final_out) begin
        unique case (k)
          KIND_CLEAR:  entry_count <= '0;
          KIND_LOAD:   if (l_class != CLS_NONE && !full) entry_count <= entry_count + 1'b1;
          KIND_RETIRE: entry_count <= wptr;
          default:     entry_count <= entry_count;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/periodic_task_release_scheduler_unit_checker.sv =====
`timescale 1ns / 1ps
module periodic_task_release_scheduler_unit_checker (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire  [2:0]        kind,
  input  wire signed [31:0] query_time,
  input  wire  [7:0]        task_ident,
  input  wire  [1:0]        task_class,
  input  wire  [30:0]       task_offset,
  input  wire  [30:0]       task_period,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire  [7:0]        hit_ident,
  input  wire               hit_valid,
  input  wire  [31:0]       next_event_time,
  input  wire               no_event,
  input  wire               status_code,
  input  wire               last_result,
  output int                fails,
  output int                pending
);
  import ptrs_pkg::*;

  localparam int DEPTH = 16;

  typedef struct {
    logic [7:0]  ident;
    logic        hv;
    logic [31:0] nxt;
    logic        none;
    logic        status;
    logic        last;
  } release_t;

  release_t due_q[$];

  logic [1:0]  tbl_class[DEPTH];
  logic [7:0]  tbl_ident[DEPTH];
  logic [30:0] tbl_offset[DEPTH];
  logic [30:0] tbl_period[DEPTH];
  int          tbl_count;

  assign pending = due_q.size();

  function automatic release_t mk(logic [7:0] id, logic hv, logic [31:0] nxt, logic none,
                                  logic st, logic last);
    release_t r;
    r.ident = id; r.hv = hv; r.nxt = nxt; r.none = none; r.status = st; r.last = last;
    return r;
  endfunction

  task automatic post(release_t r);
    due_q = {due_q, r};
  endtask

  task automatic schedule_releases(logic [2:0] k, longint t, logic [7:0] id, logic [1:0] cls,
                                   logic [30:0] off, logic [30:0] per);
    int          n;
    int          w;
    logic [63:0] d;
    logic [63:0] cand;
    logic [63:0] best;
    bit          found;
    n = 0;
    case (k)
      KIND_CLEAR: begin
        tbl_count = 0;
        post(mk(0, 0, 0, 0, 0, 1));
      end
      KIND_LOAD: begin
        if (cls != CLS_NONE && tbl_count >= DEPTH) begin
          post(mk(0, 0, 0, 0, 1, 1));
        end else begin
          if (cls != CLS_NONE) begin
            tbl_class[tbl_count] = cls;
            tbl_ident[tbl_count] = id;
            tbl_offset[tbl_count] = off;
            tbl_period[tbl_count] = per;
            tbl_count++;
          end
          post(mk(0, 0, 0, 0, 0, 1));
        end
      end
      KIND_HIT: begin
        for (int i = 0; i < tbl_count; i++)
          if (tbl_class[i] == CLS_CONT) begin
            post(mk(tbl_ident[i], 1, 0, 0, 0, 0)); n++;
          end
        for (int i = 0; i < tbl_count; i++)
          if (tbl_class[i] == CLS_ONE && longint'(tbl_offset[i]) == t) begin
            post(mk(tbl_ident[i], 1, 0, 0, 0, 0)); n++;
          end
        for (int i = 0; i < tbl_count; i++)
          if (tbl_class[i] == CLS_PER && t >= longint'(tbl_offset[i])) begin
            d = t - longint'(tbl_offset[i]);
            if ((tbl_period[i] == 0) ? (d == 0) : (d % tbl_period[i] == 0)) begin
              post(mk(tbl_ident[i], 1, 0, 0, 0, 0)); n++;
            end
          end
        if (n == 0) post(mk(0, 0, 0, 0, 0, 1));
        else due_q[$].last = 1;
      end
      KIND_NEXT: begin
        found = 0;
        best = 0;
        if (t >= 0) begin
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_class[i] == CLS_ONE) begin
              cand = 64'(tbl_offset[i]);
            end else if (tbl_class[i] == CLS_PER) begin
              if (longint'(tbl_offset[i]) >= t) cand = 64'(tbl_offset[i]);
              else if (tbl_period[i] == 0) continue;
              else begin
                d = t - longint'(tbl_offset[i]);
                cand = 64'(tbl_offset[i])
                       + ((d + tbl_period[i] - 1) / tbl_period[i]) * tbl_period[i];
              end
            end else continue;
            if (!found || cand < best) begin
              best = cand; found = 1;
            end
          end
          post(mk(0, 0, best[31:0], !found, 0, 1));
        end else begin
          post(mk(0, 0, 0, 0, 0, 1));
        end
      end
      KIND_RETIRE: begin
        w = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_class[i] == CLS_ONE && longint'(tbl_offset[i]) <= t) continue;
          tbl_class[w] = tbl_class[i];
          tbl_ident[w] = tbl_ident[i];
          tbl_offset[w] = tbl_offset[i];
          tbl_period[w] = tbl_period[i];
          w++;
        end
        tbl_count = w;
        post(mk(0, 0, 0, 0, 0, 1));
      end
      default: post(mk(0, 0, 0, 0, 0, 1));
    endcase
  endtask

  task automatic flag(string what);
    fails++;
    if (fails <= 10) $display("%0t mismatch: %s", $realtime, what);
  endtask

  initial begin
    fails = 0;
    tbl_count = 0;
  end

  always @(posedge clk) begin
    release_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          flag($sformatf("unexpected transaction ident %0d last %0d", hit_ident, last_result));
        end else begin
          e = due_q.pop_front();
          if (e.ident !== hit_ident || e.hv !== hit_valid || e.nxt !== next_event_time ||
              e.none !== no_event || e.status !== status_code || e.last !== last_result)
            flag($sformatf({"exp ident %0d hv %0d next %0d none %0d st %0d last %0d, ",
                            "got %0d %0d %0d %0d %0d %0d"},
                           e.ident, e.hv, e.nxt, e.none, e.status, e.last, hit_ident,
                           hit_valid, next_event_time, no_event, status_code, last_result));
        end
      end
      if (in_valid && !in_stall)
        schedule_releases(kind, longint'(query_time), task_ident, task_class, task_offset,
                          task_period);
    end
  end
endmodule

// ===== bench/periodic_task_release_scheduler_unit_test.sv =====
`timescale 1ns / 1ps
module periodic_task_release_scheduler_unit_test;
  import ptrs_pkg::*;

  localparam logic [2:0] KIND_SPARE_A = 3'd5;
  localparam logic [2:0] KIND_SPARE_B = 3'd6;
  localparam logic [2:0] KIND_SPARE_C = 3'd7;
  localparam int         CYCLE_LIMIT  = 2000000;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  wire                in_stall;
  logic [2:0]         kind = 0;
  logic signed [31:0] query_time = 0;
  logic [7:0]         task_ident = 0;
  logic [1:0]         task_class = 0;
  logic [30:0]        task_offset = 0;
  logic [30:0]        task_period = 0;
  wire                out_valid;
  logic               out_stall = 0;
  wire  [7:0]         hit_ident;
  wire                hit_valid;
  wire  [31:0]        next_event_time;
  wire                no_event;
  wire                status_code;
  wire                last_result;
  int                 fails;
  int                 pending;
  int                 cycles = 0;
  int                 stall_left = 0;
  int                 items = 0;
  bit                 calm = 0;
  longint             ld_off[16];
  longint             ld_per[16];
  int                 ld_n = 0;

  always #2 clk = ~clk;

  periodic_task_release_scheduler_unit u_dut (.*);

  periodic_task_release_scheduler_unit_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 0;
      if (out_valid && !out_stall && !calm) stall_left <= $urandom_range(0, 8);
    end
  end

  task automatic send(logic [2:0] k, logic signed [31:0] t, logic [7:0] id, logic [1:0] cls,
                      logic [30:0] off, logic [30:0] per);
    int g;
    kind <= k; query_time <= t; task_ident <= id; task_class <= cls;
    task_offset <= off; task_period <= per; in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items++;
    if (k == KIND_CLEAR) ld_n = 0;
    if (k == KIND_LOAD && cls != CLS_NONE && ld_n < 16) begin
      ld_off[ld_n] = off; ld_per[ld_n] = per; ld_n++;
    end
    g = calm ? 0 : $urandom_range(0, 8);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic query(logic [2:0] k, logic signed [31:0] t);
    send(k, t, 8'($urandom), 2'($urandom), 31'($urandom), 31'($urandom));
  endtask

  task automatic load(logic [7:0] id, logic [1:0] cls, logic [30:0] off, logic [30:0] per);
    send(KIND_LOAD, $urandom, id, cls, off, per);
  endtask

  function automatic logic signed [31:0] pick_time();
    int     i;
    longint t;
    case ($urandom_range(0, 9))
      0: return -$signed({1'b0, 31'($urandom_range(1, 1000))});
      1: return $urandom;
      2, 3: return $urandom_range(0, 300);
      default: begin
        if (ld_n == 0) return $urandom_range(0, 300);
        i = $urandom_range(0, ld_n - 1);
        t = ld_off[i] + longint'($urandom_range(0, 5)) * ld_per[i]
            + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : 0);
        return t[31:0];
      end
    endcase
  endfunction

  initial begin
    logic [30:0] o;
    logic [30:0] p;
    repeat (5) @(posedge clk);
    rst <= 0;

    query(KIND_HIT, 0);
    query(KIND_NEXT, 5);
    load(8'h00, CLS_CONT, 0, 1);
    load(8'hFF, CLS_PER, 31'h7FFFFFFF, 31'h7FFFFFFF);
    load(8'h5A, CLS_PER, 10, 0);
    load(8'hA5, CLS_ONE, 10, 3);
    load(8'h33, CLS_NONE, 4, 4);
    load(8'h21, CLS_PER, 4, 3);
    query(KIND_HIT, 10);
    query(KIND_HIT, 32'sh7FFFFFFF);
    query(KIND_NEXT, -1);
    query(KIND_NEXT, 32'sh80000000);
    query(KIND_NEXT, 11);
    query(KIND_NEXT, 32'sh7FFFFFFE);
    query(KIND_RETIRE, 10);
    query(KIND_NEXT, 0);
    query(KIND_SPARE_A, 1);
    query(KIND_SPARE_B, 2);
    query(KIND_SPARE_C, 3);
    query(KIND_CLEAR, 0);
    for (int i = 0; i < 17; i++) load(8'(i), CLS_ONE, 31'(20 + i), 1);
    query(KIND_HIT, 25);

    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(posedge clk);

    while (items < 300) begin
      calm = ($urandom_range(0, 4) == 0);
      query(KIND_CLEAR, $urandom);
      repeat ($urandom_range(0, 10) == 0 ? 18 : $urandom_range(1, 16)) begin
        if ($urandom_range(0, 5) == 0) begin
          o = 31'($urandom); p = 31'($urandom);
        end else begin
          o = 31'($urandom_range(0, 200)); p = 31'($urandom_range(1, 50));
        end
        if ($urandom_range(0, 20) == 0) p = 0;
        load(8'($urandom), $urandom_range(0, 20) == 0 ? CLS_NONE : 2'($urandom_range(0, 2)),
             o, p);
      end
      repeat ($urandom_range(3, 10)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: query(KIND_HIT, pick_time());
          5, 6, 7: query(KIND_NEXT, pick_time());
          8: query(KIND_RETIRE, pick_time());
          default: query(3'($urandom_range(0, 7)), pick_time());
        endcase
      end
    end
    in_valid <= 0;
    calm = 0;

    @(negedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
